/* rtl/quad_psd_position_regmap_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quad PSD position block.
// Every check is clocked on i_clk and is off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUAD_PSD_POSITION_REGMAP_MACROS_SVH
`define QUAD_PSD_POSITION_REGMAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QPSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qpsd_pkg.sv */
// ----------------------------------------------------------------------------
// qpsd_pkg
// Shared constants, payload types and register map layout of the quad PSD
// position block.
// ----------------------------------------------------------------------------
`default_nettype none

package qpsd_pkg;

    // Converter and register map geometry.
    localparam int SAMPLE_BITS   = 12;
    localparam int MAP_WORDS     = 16;
    localparam int MAP_AW        = $clog2(MAP_WORDS);
    localparam int WORD_BITS     = 16;
    localparam int BYTE_BITS     = 8;
    localparam int FRAME_SAMPLES = 10;
    localparam int NUM_LANES     = 2;
    localparam int QUADS         = 4;
    localparam int LANE_WORDS    = 3;

    // Arithmetic widths: a quadrant sum, a difference magnitude, the scale.
    localparam int SUM_BITS      = SAMPLE_BITS + 2;
    localparam int MAG_BITS      = SAMPLE_BITS + 1;
    localparam int SHIFT_BITS    = 4;
    localparam int MAX_SHIFT     = (1 << SHIFT_BITS) - 1;
    localparam int DVD_BITS      = MAG_BITS + MAX_SHIFT;
    localparam int DIV_CNT_BITS  = $clog2(DVD_BITS);

    // Position saturation limit.
    localparam logic [WORD_BITS-1:0] POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    // Item function codes.
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Configuration register indexes and APB address width.
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_FRAC_BITS = 1'b0;

    // Input item of the command channel.
    typedef struct packed {
        logic                   func;
        logic [SAMPLE_BITS-1:0] sample_0;
        logic [SAMPLE_BITS-1:0] sample_1;
        logic [SAMPLE_BITS-1:0] sample_2;
        logic [SAMPLE_BITS-1:0] sample_3;
        logic [SAMPLE_BITS-1:0] sample_4;
        logic [SAMPLE_BITS-1:0] sample_5;
        logic [SAMPLE_BITS-1:0] sample_6;
        logic [SAMPLE_BITS-1:0] sample_7;
        logic [SAMPLE_BITS-1:0] sample_8;
        logic [SAMPLE_BITS-1:0] sample_9;
        logic [7:0]             read_address;
    } t_item;

    // Result item: one byte of a register read.
    typedef struct packed {
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 last_byte;
        logic                 bad_address;
    } t_result;

    // Four quadrant samples of one detector, index i is quadrant i.
    typedef logic [QUADS-1:0][SAMPLE_BITS-1:0] t_quad;

    // What one lane hands to the merge stage.
    typedef struct packed {
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] y;
        logic [WORD_BITS-1:0] intensity;
    } t_lane_res;

endpackage

`default_nettype wire

/* rtl/qpsd_div.sv */
// ----------------------------------------------------------------------------
// qpsd_div
// Restoring divider, one quotient bit per cycle. Divides a magnitude scaled
// by 2^shift by a quadrant sum, then applies sign and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module qpsd_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic                               i_neg,
    input  wire logic [qpsd_pkg::MAG_BITS-1:0]      i_mag,
    input  wire logic [qpsd_pkg::SUM_BITS-1:0]      i_den,
    input  wire logic [qpsd_pkg::SHIFT_BITS-1:0]    i_shift,
    output logic                                    o_done,
    output logic [qpsd_pkg::WORD_BITS-1:0]          o_quot
);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_STEP,
        DV_FIX
    } t_dv_state;

    localparam logic [qpsd_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
        qpsd_pkg::DIV_CNT_BITS'(qpsd_pkg::DVD_BITS - 1);

    t_dv_state                             r_state;
    logic [qpsd_pkg::DVD_BITS-1:0]         r_dvd;
    logic [qpsd_pkg::SUM_BITS-1:0]         r_rem;
    logic [qpsd_pkg::SUM_BITS-1:0]         r_den;
    logic [qpsd_pkg::WORD_BITS-1:0]        r_quo;
    logic [qpsd_pkg::DIV_CNT_BITS-1:0]     r_cnt;
    logic                                  r_neg;
    logic                                  r_done;
    logic [qpsd_pkg::WORD_BITS-1:0]        r_quot;

    logic [qpsd_pkg::SUM_BITS:0]           w_trial;
    logic                                  w_fits;
    logic [qpsd_pkg::SUM_BITS:0]           w_diff;
    logic [qpsd_pkg::SUM_BITS-1:0]         n_rem;
    logic [qpsd_pkg::WORD_BITS-1:0]        n_quot;

    // Trial subtraction of one restoring step.
    always_comb begin
        w_trial = {r_rem, r_dvd[qpsd_pkg::DVD_BITS-1]};
        w_fits  = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_fits ? w_diff[qpsd_pkg::SUM_BITS-1:0]
                         : w_trial[qpsd_pkg::SUM_BITS-1:0];
    end

    // Sign and saturation of the finished quotient; a zero sum gives zero.
    always_comb begin
        if (r_den == '0) begin
            n_quot = '0;
        end else if (r_neg) begin
            n_quot = (~r_quo) + qpsd_pkg::WORD_BITS'(1);
        end else if (r_quo[qpsd_pkg::WORD_BITS-1]) begin
            n_quot = qpsd_pkg::POS_MAX;
        end else begin
            n_quot = r_quo;
        end
    end

    // Sequencer with the quotient result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= {{(qpsd_pkg::DVD_BITS - qpsd_pkg::MAG_BITS){1'b0}}, i_mag}
                                   << i_shift;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_den   <= i_den;
                        r_neg   <= i_neg;
                        r_state <= DV_STEP;
                    end
                end
                DV_STEP: begin
                    r_dvd <= {r_dvd[qpsd_pkg::DVD_BITS-2:0], 1'b0};
                    r_rem <= n_rem;
                    r_quo <= {r_quo[qpsd_pkg::WORD_BITS-2:0], w_fits};
                    r_cnt <= r_cnt + qpsd_pkg::DIV_CNT_BITS'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_state <= DV_FIX;
                    end
                end
                DV_FIX: begin
                    r_quot  <= n_quot;
                    r_done  <= 1'b1;
                    r_state <= DV_IDLE;
                end
                default: begin
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* rtl/qpsd_lane.sv */
// ----------------------------------------------------------------------------
// qpsd_lane
// One detector lane: forms intensity and the x and y differences of four
// quadrant samples, then runs both positions through its divider in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module qpsd_lane (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire qpsd_pkg::t_quad                    i_quad,
    input  wire logic [qpsd_pkg::SHIFT_BITS-1:0]    i_frac_bits,
    output logic                                    o_done,
    output qpsd_pkg::t_lane_res                     o_res
);

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_X,
        LN_Y
    } t_ln_state;

    t_ln_state                          r_state;
    logic [qpsd_pkg::SUM_BITS-1:0]      r_sum;
    logic                               r_y_neg;
    logic [qpsd_pkg::MAG_BITS-1:0]      r_y_mag;
    logic [qpsd_pkg::WORD_BITS-1:0]     r_x_res;
    logic [qpsd_pkg::WORD_BITS-1:0]     r_y_res;
    logic                               r_done;

    logic [qpsd_pkg::MAG_BITS-1:0]      w_right;
    logic [qpsd_pkg::MAG_BITS-1:0]      w_left;
    logic [qpsd_pkg::MAG_BITS-1:0]      w_top;
    logic [qpsd_pkg::MAG_BITS-1:0]      w_bottom;
    logic [qpsd_pkg::SUM_BITS-1:0]      w_sum;
    logic                               w_x_neg;
    logic [qpsd_pkg::MAG_BITS-1:0]      w_x_mag;
    logic                               w_y_neg;
    logic [qpsd_pkg::MAG_BITS-1:0]      w_y_mag;

    logic                               w_div_start;
    logic                               w_div_neg;
    logic [qpsd_pkg::MAG_BITS-1:0]      w_div_mag;
    logic [qpsd_pkg::SUM_BITS-1:0]      w_div_den;
    logic                               w_div_done;
    logic [qpsd_pkg::WORD_BITS-1:0]     w_div_quot;

    // Pair sums, intensity and sign-magnitude differences of the quadrants.
    always_comb begin
        w_right  = {1'b0, i_quad[3]} + {1'b0, i_quad[2]};
        w_left   = {1'b0, i_quad[1]} + {1'b0, i_quad[0]};
        w_top    = {1'b0, i_quad[3]} + {1'b0, i_quad[0]};
        w_bottom = {1'b0, i_quad[1]} + {1'b0, i_quad[2]};
        w_sum    = {1'b0, w_right} + {1'b0, w_left};
        w_x_neg  = (w_right < w_left);
        w_x_mag  = w_x_neg ? (w_left - w_right) : (w_right - w_left);
        w_y_neg  = (w_top < w_bottom);
        w_y_mag  = w_y_neg ? (w_bottom - w_top) : (w_top - w_bottom);
    end

    // The divider takes x straight from the samples, y from the held copy.
    always_comb begin
        w_div_start = ((r_state == LN_IDLE) && i_start) ||
                      ((r_state == LN_X) && w_div_done);
        w_div_neg   = (r_state == LN_IDLE) ? w_x_neg : r_y_neg;
        w_div_mag   = (r_state == LN_IDLE) ? w_x_mag : r_y_mag;
        w_div_den   = (r_state == LN_IDLE) ? w_sum   : r_sum;
    end

    qpsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_neg   (w_div_neg),
        .i_mag   (w_div_mag),
        .i_den   (w_div_den),
        .i_shift (i_frac_bits),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Lane sequencer: x division, then y division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                LN_IDLE: begin
                    if (i_start) begin
                        r_sum   <= w_sum;
                        r_y_neg <= w_y_neg;
                        r_y_mag <= w_y_mag;
                        r_state <= LN_X;
                    end
                end
                LN_X: begin
                    if (w_div_done) begin
                        r_x_res <= w_div_quot;
                        r_state <= LN_Y;
                    end
                end
                LN_Y: begin
                    if (w_div_done) begin
                        r_y_res <= w_div_quot;
                        r_done  <= 1'b1;
                        r_state <= LN_IDLE;
                    end
                end
                default: begin
                    r_state <= LN_IDLE;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_res.x         = r_x_res;
    assign o_res.y         = r_y_res;
    assign o_res.intensity = {{(qpsd_pkg::WORD_BITS - qpsd_pkg::SUM_BITS){1'b0}}, r_sum};

endmodule

`default_nettype wire

/* rtl/quad_psd_position_regmap.sv */
// ----------------------------------------------------------------------------
// quad_psd_position_regmap
// Dual quadrant-detector position engine with a 16-word register map that
// is read out byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a rising edge with start high and busy low.
//   func = frame: the ten samples go into map words 0 to 9 at once. Two lanes,
//   one per detector, then compute x, y and intensity in parallel; each lane
//   runs x and then y through its own bit-serial divider (28 steps plus load
//   and fix). When both lanes are done the merge stage writes words 10 to 15
//   and busy drops; no new frame is taken before then. A frame returns no result.
//   func = read: the addressed word is sent as two transfers on o_valid, the
//   high byte in the cycle after acceptance and the low byte in the next,
//   with last_byte set on the low byte; busy is high while the high byte is out.
//   An address of 16 or more sends two zero bytes with bad_address set.
//   The receiver cannot stall; each transfer lasts one cycle.
//   frac_bits sits at APB byte address 0; the user must write it only while idle,
//   as the block does not check busy. Reset clears the map, frac_bits and all control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quad_psd_position_regmap_macros.svh"

module quad_psd_position_regmap (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Command channel.
    input  wire logic                               start,
    output logic                                    busy,
    input  wire qpsd_pkg::t_item                    i_item,
    // Result channel.
    output logic                                    o_valid,
    output qpsd_pkg::t_result                       o_result,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [qpsd_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [qpsd_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [qpsd_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                    pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_RD_LO
    } t_state;

    t_state                                     r_state;
    logic [qpsd_pkg::WORD_BITS-1:0]             r_map [qpsd_pkg::MAP_WORDS];
    logic [qpsd_pkg::SHIFT_BITS-1:0]            r_frac_bits;
    logic                                       r_valid;
    qpsd_pkg::t_result                          r_result;
    logic [qpsd_pkg::BYTE_BITS-1:0]             r_lo_byte;
    logic                                       r_lo_bad;

    logic                                       w_accept;
    logic                                       w_frame_go;
    logic                                       w_read_go;
    logic                                       w_merge;
    logic                                       w_cfg_wr;
    logic                                       w_addr_ok;
    logic [qpsd_pkg::WORD_BITS-1:0]             w_rd_word;
    logic [qpsd_pkg::SAMPLE_BITS-1:0]           w_samples [qpsd_pkg::FRAME_SAMPLES];
    qpsd_pkg::t_quad                            w_quad    [qpsd_pkg::NUM_LANES];
    logic [qpsd_pkg::NUM_LANES-1:0]             w_lane_done;
    qpsd_pkg::t_lane_res                        w_lane_res [qpsd_pkg::NUM_LANES];

    // Command decode.
    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_frame_go = w_accept && (i_item.func == qpsd_pkg::FUNC_FRAME);
    assign w_read_go  = w_accept && (i_item.func == qpsd_pkg::FUNC_READ);
    assign w_merge    = (r_state == ST_CALC) && (&w_lane_done);

    // Samples of the frame in channel order.
    always_comb begin
        w_samples[0] = i_item.sample_0;
        w_samples[1] = i_item.sample_1;
        w_samples[2] = i_item.sample_2;
        w_samples[3] = i_item.sample_3;
        w_samples[4] = i_item.sample_4;
        w_samples[5] = i_item.sample_5;
        w_samples[6] = i_item.sample_6;
        w_samples[7] = i_item.sample_7;
        w_samples[8] = i_item.sample_8;
        w_samples[9] = i_item.sample_9;
    end

    // One lane per detector, each on its own four quadrants.
    for (genvar g = 0; g < qpsd_pkg::NUM_LANES; g++) begin : g_lane
        for (genvar q = 0; q < qpsd_pkg::QUADS; q++) begin : g_quad
            assign w_quad[g][q] = w_samples[g * qpsd_pkg::QUADS + q];
        end

        qpsd_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_start     (w_frame_go),
            .i_quad      (w_quad[g]),
            .i_frac_bits (r_frac_bits),
            .o_done      (w_lane_done[g]),
            .o_res       (w_lane_res[g])
        );
    end

    // Register map: raw samples on frame acceptance, lane results on merge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qpsd_pkg::MAP_WORDS; i++) begin
                r_map[i] <= '0;
            end
        end else begin
            if (w_frame_go) begin
                for (int i = 0; i < qpsd_pkg::FRAME_SAMPLES; i++) begin
                    r_map[i] <= {{(qpsd_pkg::WORD_BITS - qpsd_pkg::SAMPLE_BITS){1'b0}},
                                 w_samples[i]};
                end
            end
            if (w_merge) begin
                for (int l = 0; l < qpsd_pkg::NUM_LANES; l++) begin
                    r_map[qpsd_pkg::FRAME_SAMPLES + qpsd_pkg::LANE_WORDS * l]
                        <= w_lane_res[l].x;
                    r_map[qpsd_pkg::FRAME_SAMPLES + qpsd_pkg::LANE_WORDS * l + 1]
                        <= w_lane_res[l].y;
                    r_map[qpsd_pkg::FRAME_SAMPLES + qpsd_pkg::LANE_WORDS * l + 2]
                        <= w_lane_res[l].intensity;
                end
            end
        end
    end

    // Addressed word of a read command.
    always_comb begin
        w_addr_ok = (i_item.read_address < 8'(qpsd_pkg::MAP_WORDS));
        w_rd_word = w_addr_ok ? r_map[i_item.read_address[qpsd_pkg::MAP_AW-1:0]] : '0;
    end

    // Control sequencer with the result transfer register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_frame_go) begin
                        r_state <= ST_CALC;
                    end else if (w_read_go) begin
                        r_valid              <= 1'b1;
                        r_result.tx_byte     <= w_rd_word[qpsd_pkg::WORD_BITS-1:
                                                          qpsd_pkg::BYTE_BITS];
                        r_result.last_byte   <= 1'b0;
                        r_result.bad_address <= !w_addr_ok;
                        r_lo_byte            <= w_rd_word[qpsd_pkg::BYTE_BITS-1:0];
                        r_lo_bad             <= !w_addr_ok;
                        r_state              <= ST_RD_LO;
                    end
                end
                ST_CALC: begin
                    if (w_merge) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD_LO: begin
                    r_valid              <= 1'b1;
                    r_result.tx_byte     <= r_lo_byte;
                    r_result.last_byte   <= 1'b1;
                    r_result.bad_address <= r_lo_bad;
                    r_state              <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Configuration register: frac_bits at the first word.
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[qpsd_pkg::PADDR_BITS-1] == qpsd_pkg::REG_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= '0;
        end else if (w_cfg_wr) begin
            r_frac_bits <= pwdata[qpsd_pkg::SHIFT_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[qpsd_pkg::PADDR_BITS-1] == qpsd_pkg::REG_FRAC_BITS)
                  ? {{(qpsd_pkg::PDATA_BITS - qpsd_pkg::SHIFT_BITS){1'b0}}, r_frac_bits}
                  : '0;

    // Checks on sequencing and result content.
    `QPSD_ASSERT_NEXT(a_lo_follows_hi, o_valid && !o_result.last_byte, o_valid && o_result.last_byte, "low byte did not follow high byte")
    `QPSD_ASSERT_NOW(a_lo_after_hi, o_valid && o_result.last_byte, $past(o_valid) && !$past(o_result.last_byte), "low byte without high byte")
    `QPSD_ASSERT_NOW(a_bad_is_zero, o_valid && o_result.bad_address, o_result.tx_byte == '0, "bad address returned data")
    `QPSD_ASSERT_NOW(a_lanes_aligned, w_lane_done[0], w_lane_done[1], "detector lanes finished apart")
    `QPSD_ASSERT_NEXT(a_frame_silent, w_frame_go, !o_valid && busy, "frame produced a transfer")

endmodule

`default_nettype wire

/* tb/tb_quad_psd_position_regmap.sv */
// ----------------------------------------------------------------------------
// tb_quad_psd_position_regmap
// Self-checking testbench for the dual quadrant-detector position block.
// A behavioral copy of the register map and the position arithmetic predicts
// the two bytes of every register read. A checker compares each byte transfer
// with the oldest prediction. Directed tests cover the sample extremes, zero
// intensity, bad addresses and the fraction scaling. Random traffic then runs
// in several fraction settings with random gaps on the command side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quad_psd_position_regmap;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASE_ITEMS    = 205;
    localparam int SAMPLE_MAX     = (1 << qpsd_pkg::SAMPLE_BITS) - 1;
    localparam int ITEM_BITS      = $bits(qpsd_pkg::t_item);
    localparam logic [qpsd_pkg::PADDR_BITS-1:0] FRAC_ADDR =
        qpsd_pkg::PADDR_BITS'(4 * int'(qpsd_pkg::REG_FRAC_BITS));

    // Clock, reset and block ports.
    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    qpsd_pkg::t_item                     i_item;
    logic                                o_valid;
    qpsd_pkg::t_result                   o_result;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [qpsd_pkg::PADDR_BITS-1:0]     paddr;
    logic [qpsd_pkg::PDATA_BITS-1:0]     pwdata;
    logic [qpsd_pkg::PDATA_BITS-1:0]     prdata;
    logic                                pready;

    // Shadow of the block state and the bytes still to come.
    logic [qpsd_pkg::WORD_BITS-1:0]      shadow_map [qpsd_pkg::MAP_WORDS];
    logic [3:0]                          shadow_frac;
    qpsd_pkg::t_result                   pending_bytes [$];
    int                                  mismatches;
    int                                  stall_cycles;
    int                                  burst_left;

    quad_psd_position_regmap uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Scaled position: (num * 2^frac) / den, truncated toward zero, saturated.
    function automatic logic [qpsd_pkg::WORD_BITS-1:0] position_word(input int num,
                                                                     input int den);
        longint mag;
        longint quo;
        bit     neg;
        if (den == 0) return '0;
        neg = (num < 0);
        mag = neg ? -longint'(num) : longint'(num);
        quo = (mag << shadow_frac) / den;
        if (neg) begin
            if (quo > 32768) quo = 32768;
            return qpsd_pkg::WORD_BITS'(-quo);
        end
        if (quo > 32767) quo = 32767;
        return qpsd_pkg::WORD_BITS'(quo);
    endfunction

    // Position and intensity words of one detector.
    task automatic update_detector(input int base, input int q0, input int q1,
                                   input int q2, input int q3);
        int sum;
        int dx;
        int dy;
        sum = q0 + q1 + q2 + q3;
        dx  = (q3 + q2) - (q1 + q0);
        dy  = (q3 + q0) - (q1 + q2);
        shadow_map[base]     = position_word(dx, sum);
        shadow_map[base + 1] = position_word(dy, sum);
        shadow_map[base + 2] = qpsd_pkg::WORD_BITS'(sum);
    endtask

    // Apply one accepted command to the shadow map and queue its bytes.
    task automatic predict_command(input qpsd_pkg::t_item it);
        int                             raw [qpsd_pkg::FRAME_SAMPLES];
        logic [qpsd_pkg::WORD_BITS-1:0] word;
        logic                           bad;
        qpsd_pkg::t_result              hi_byte;
        qpsd_pkg::t_result              lo_byte;
        if (it.func == qpsd_pkg::FUNC_FRAME) begin
            raw = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3, it.sample_4,
                    it.sample_5, it.sample_6, it.sample_7, it.sample_8, it.sample_9};
            for (int i = 0; i < qpsd_pkg::FRAME_SAMPLES; i++) begin
                shadow_map[i] = qpsd_pkg::WORD_BITS'(raw[i]);
            end
            update_detector(qpsd_pkg::FRAME_SAMPLES, raw[0], raw[1], raw[2], raw[3]);
            update_detector(qpsd_pkg::FRAME_SAMPLES + qpsd_pkg::LANE_WORDS,
                            raw[4], raw[5], raw[6], raw[7]);
        end else begin
            bad  = (it.read_address >= qpsd_pkg::MAP_WORDS);
            word = bad ? '0 : shadow_map[it.read_address[qpsd_pkg::MAP_AW-1:0]];
            hi_byte.tx_byte     = word[15:8];
            hi_byte.last_byte   = 1'b0;
            hi_byte.bad_address = bad;
            lo_byte.tx_byte     = word[7:0];
            lo_byte.last_byte   = 1'b1;
            lo_byte.bad_address = bad;
            pending_bytes.push_back(hi_byte);
            pending_bytes.push_back(lo_byte);
        end
    endtask

    // Compare each byte transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin : check_byte
            qpsd_pkg::t_result want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected byte transfer: tx_byte %0h", o_result.tx_byte);
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_result.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %0h, actual %0h", want.tx_byte,
                           o_result.tx_byte);
                    mismatches++;
                end
                if (o_result.last_byte !== want.last_byte) begin
                    $error("last_byte: expected %0b, actual %0b", want.last_byte,
                           o_result.last_byte);
                    mismatches++;
                end
                if (o_result.bad_address !== want.bad_address) begin
                    $error("bad_address: expected %0b, actual %0b", want.bad_address,
                           o_result.bad_address);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL quad_psd_position_regmap");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one command and hold it until the block takes it.
    task automatic send_item(input qpsd_pkg::t_item it);
        bit taken;
        start  <= 1'b1;
        i_item <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        predict_command(it);
    endtask

    // Random gap after a transfer: mostly none or short, a few long.
    task automatic command_gap();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        if (pick < 5) begin
            burst_left = $urandom_range(15, 40);
            return;
        end
        if (pick < 55) len = 0;
        else if (pick < 90) len = $urandom_range(1, 3);
        else len = $urandom_range(10, 40);
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Wait until every byte has come and the block has gone idle.
    task automatic wait_drained();
        bit idle;
        start <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        idle = 1'b0;
        while (!idle) begin
            @(negedge i_clk);
            idle = !busy;
            @(posedge i_clk);
        end
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input logic write,
                                input logic [qpsd_pkg::PDATA_BITS-1:0] wdata,
                                output logic [qpsd_pkg::PDATA_BITS-1:0] rdata);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= FRAC_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done  = pready;
            rdata = prdata;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write frac_bits, then read it back.
    task automatic set_frac(input logic [3:0] value);
        logic [qpsd_pkg::PDATA_BITS-1:0] rdata;
        apb_transfer(1'b1, {$urandom} & ~32'hF | qpsd_pkg::PDATA_BITS'(value), rdata);
        shadow_frac = value;
        apb_transfer(1'b0, '0, rdata);
        if (rdata[3:0] !== value) begin
            $error("frac_bits: expected %0d, actual %0d", value, rdata[3:0]);
            mismatches++;
        end
    endtask

    function automatic qpsd_pkg::t_item read_cmd(input int addr);
        qpsd_pkg::t_item it;
        it              = ITEM_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.func         = qpsd_pkg::FUNC_READ;
        it.read_address = 8'(addr);
        return it;
    endfunction

    function automatic qpsd_pkg::t_item frame_cmd(input int q [qpsd_pkg::FRAME_SAMPLES]);
        qpsd_pkg::t_item it;
        it.func         = qpsd_pkg::FUNC_FRAME;
        it.sample_0     = qpsd_pkg::SAMPLE_BITS'(q[0]);
        it.sample_1     = qpsd_pkg::SAMPLE_BITS'(q[1]);
        it.sample_2     = qpsd_pkg::SAMPLE_BITS'(q[2]);
        it.sample_3     = qpsd_pkg::SAMPLE_BITS'(q[3]);
        it.sample_4     = qpsd_pkg::SAMPLE_BITS'(q[4]);
        it.sample_5     = qpsd_pkg::SAMPLE_BITS'(q[5]);
        it.sample_6     = qpsd_pkg::SAMPLE_BITS'(q[6]);
        it.sample_7     = qpsd_pkg::SAMPLE_BITS'(q[7]);
        it.sample_8     = qpsd_pkg::SAMPLE_BITS'(q[8]);
        it.sample_9     = qpsd_pkg::SAMPLE_BITS'(q[9]);
        it.read_address = 8'($urandom);
        return it;
    endfunction

    // Random frame with one of several sample patterns.
    function automatic qpsd_pkg::t_item random_frame();
        int q [qpsd_pkg::FRAME_SAMPLES];
        int pattern;
        pattern = $urandom_range(0, 7);
        for (int i = 0; i < qpsd_pkg::FRAME_SAMPLES; i++) begin
            case (pattern)
                2: q[i] = SAMPLE_MAX;
                3: q[i] = $urandom_range(0, 3);
                4: q[i] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                default: q[i] = $urandom_range(0, SAMPLE_MAX);
            endcase
        end
        // Zero intensity on one detector.
        for (int i = 0; i < qpsd_pkg::QUADS; i++) begin
            if (pattern == 0) q[i] = 0;
            if (pattern == 1) q[qpsd_pkg::QUADS + i] = 0;
        end
        return frame_cmd(q);
    endfunction

    // Random read, mostly inside the map.
    function automatic qpsd_pkg::t_item random_read();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return read_cmd($urandom_range(0, qpsd_pkg::MAP_WORDS - 1));
        if (pick < 85) return read_cmd(255);
        return read_cmd($urandom_range(qpsd_pkg::MAP_WORDS, 255));
    endfunction

    // The map reads as zeros after reset; addresses past the map flag an error.
    task automatic test_reset_values();
        send_item(read_cmd(0));
        send_item(read_cmd(qpsd_pkg::MAP_WORDS - 1));
        send_item(read_cmd(qpsd_pkg::MAP_WORDS));
        send_item(read_cmd(255));
        wait_drained();
    endtask

    // Full-scale and zero samples, zero intensity, plain integer positions.
    task automatic test_frame_extremes();
        set_frac(4'd0);
        send_item(frame_cmd('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                              0, 0, 0, 0, SAMPLE_MAX, 0}));
        send_item(read_cmd(3));
        send_item(read_cmd(8));
        send_item(read_cmd(9));
        send_item(read_cmd(10));
        send_item(read_cmd(12));
        send_item(read_cmd(13));
        send_item(read_cmd(15));
        send_item(frame_cmd('{SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0, 0, 0, SAMPLE_MAX, 0,
                              SAMPLE_MAX}));
        send_item(read_cmd(10));
        send_item(read_cmd(11));
        send_item(read_cmd(13));
        send_item(read_cmd(14));
        wait_drained();
    endtask

    // Fraction setting of 14: positions of unit magnitude both ways.
    task automatic test_fraction_scaling();
        set_frac(4'd14);
        send_item(frame_cmd('{SAMPLE_MAX, 0, 0, 0, 1, 2, 3, SAMPLE_MAX, 0, 0}));
        send_item(read_cmd(10));
        send_item(read_cmd(11));
        send_item(read_cmd(14));
        wait_drained();
    endtask

    // Random frames and reads over several fraction settings.
    task automatic test_random_traffic();
        logic [3:0] frac_plan [6];
        frac_plan = '{4'd0, 4'd14, 4'd7, 4'($urandom_range(1, 13)),
                      4'($urandom_range(0, 14)), 4'd1};
        foreach (frac_plan[p]) begin
            set_frac(frac_plan[p]);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 3) send_item(random_frame());
                else send_item(random_read());
                command_gap();
            end
            wait_drained();
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        burst_left   = 0;
        shadow_frac  = '0;
        foreach (shadow_map[i]) shadow_map[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_frame_extremes();
        test_fraction_scaling();
        test_random_traffic();
        wait_drained();

        if (mismatches == 0) begin
            $display("PASS quad_psd_position_regmap");
        end else begin
            $display("FAIL quad_psd_position_regmap");
        end
        $finish;
    end

endmodule
